[design/dwr_pkg.sv]
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and constants of the table-driven word recognizer: request
// and result payloads, operation codes, table entry layout, clear sequencer.
// ----------------------------------------------------------------------------
package dwr_pkg;

    localparam int STATE_W  = 6;
    localparam int SYMBOL_W = 8;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_WRITE_TRANS = 2'd0,
        OP_SET_FLAG    = 2'd1,
        OP_FEED        = 2'd2,
        OP_EMPTY_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 operation;
        logic [STATE_W-1:0]  source_state;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  target_state;
        logic                accepting_bit;
        logic                word_start;
        logic                word_end;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [STATE_W-1:0] last_state;
        logic               no_transition;
    } res_t;

    // One transition table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } entry_t;

    // Post-reset clear sequencer
    typedef enum logic {
        CLR_SWEEP = 1'b0,
        CLR_IDLE  = 1'b1
    } clr_state_t;

endpackage

[design/dfa_word_recognizer.sv]
// ----------------------------------------------------------------------------
// dfa_word_recognizer
// Table-driven deterministic automaton: holds transitions and accepting
// flags, walks words one symbol per request and reports each finished word.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation per
//   request: write a transition, set an accepting flag, feed one symbol, or
//   query the empty word. res channel (res_valid / res_stall / res) returns
//   one result for a fed symbol marked word_end and for each empty word query.
//   cfg_we / cfg_wdata load the start state; write it only while idle.
//   Throughput: one request per cycle while req_stall is low. The table read
//   for a symbol is issued at acceptance and its registered output feeds the
//   next symbol's address. A result passes the table read stage, the flag
//   read stage and the result register, any of which a stall can hold.
//   Reset: a clearing pass writes every table entry and flag, one address a
//   cycle, over NUM_ROWS * 2**ceil(log2(ALPHABET_SIZE)) addresses (16384 at the
//   defaults); req_stall stays high during it.
//   Stall: while res_stall holds a result, requests still enter the table read and
//   flag read stages until a result-bearing one waits in the flag stage and req_stall rises.
// ----------------------------------------------------------------------------
module dfa_word_recognizer #(
    parameter int NUM_STATES    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dwr_pkg::STATE_W-1:0]   cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  dwr_pkg::req_t                 req,
    output logic                          res_valid,
    input  logic                          res_stall,
    output dwr_pkg::res_t                 res
);

    localparam int STATE_W    = dwr_pkg::STATE_W;
    localparam int SYMBOL_W   = dwr_pkg::SYMBOL_W;
    localparam int STATE_SPAN = 1 << STATE_W;
    localparam int NUM_ROWS   = (NUM_STATES < STATE_SPAN) ? NUM_STATES : STATE_SPAN;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int SYM_W      = $clog2(ALPHABET_SIZE);
    localparam int TBL_DEPTH  = NUM_ROWS << SYM_W;
    localparam int TBL_ADDR_W = ROW_W + SYM_W;
    localparam int ENTRY_W    = $bits(dwr_pkg::entry_t);
    localparam logic [STATE_W:0]  ROW_LIMIT = (STATE_W + 1)'(NUM_ROWS);
    localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W + 1)'(ALPHABET_SIZE);

    // Configuration and walk state
    logic [STATE_W-1:0] start_state_reg;
    logic [STATE_W-1:0] walk_state_reg;
    logic               walk_dead_reg;

    // Clear sequencer
    logic                  clr_busy;
    logic [TBL_ADDR_W-1:0] clr_addr;

    // Table port
    logic                  tbl_we;
    logic [TBL_ADDR_W-1:0] tbl_waddr;
    logic [ENTRY_W-1:0]    tbl_wdata;
    logic                  tbl_re;
    logic [TBL_ADDR_W-1:0] tbl_raddr;
    logic [ENTRY_W-1:0]    tbl_rdata;

    // Flag port
    logic             flg_we;
    logic [ROW_W-1:0] flg_waddr;
    logic [0:0]       flg_wdata;
    logic             flg_re;
    logic [ROW_W-1:0] flg_raddr;
    logic [0:0]       flg_rdata;

    // Accept side
    logic               accept;
    logic [STATE_W-1:0] walk_state;
    logic               walk_dead;
    logic [STATE_W-1:0] base_state;
    logic               base_dead;
    logic               req_sym_ok;
    logic               lookup_ok;
    logic               trans_ok;
    dwr_pkg::entry_t    new_entry;

    // Table read stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    dwr_pkg::req_t      s1_req_reg;
    logic [STATE_W-1:0] s1_base_state_reg;
    logic               s1_lookup_ok_reg;
    dwr_pkg::entry_t    s1_entry;
    logic               s1_hit;
    logic [STATE_W-1:0] s1_next_state;
    logic               s1_next_dead;
    logic               s1_is_feed;
    logic               s1_has_res;
    logic [STATE_W-1:0] s1_last_state;
    logic               s1_end_dead;
    logic               s1_end_ok;
    logic               s1_src_ok;
    logic               s1_move;
    logic               s1_free;

    // Flag read stage
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_has_res_reg;
    logic [STATE_W-1:0] s2_state_reg;
    logic               s2_dead_reg;
    logic               s2_flag_ok_reg;
    logic               s2_move;
    logic               s2_free;

    // Result register
    logic          res_valid_reg;
    logic          res_valid_next;
    dwr_pkg::res_t res_reg;
    logic          out_free;

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    assign out_free  = !res_valid_reg || !res_stall;
    assign s2_move   = s2_valid_reg && (!s2_has_res_reg || out_free);
    assign s2_free   = !s2_valid_reg || s2_move;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s1_move;
    assign req_stall = clr_busy || !s1_free;
    assign accept    = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // Clear sequencer
    // ------------------------------------------------------------------
    dwr_clear #(
        .DEPTH (TBL_DEPTH)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    // ------------------------------------------------------------------
    // Accept side: forward the walk from the table stage, form the lookup
    // ------------------------------------------------------------------
    assign s1_is_feed = (s1_req_reg.operation == dwr_pkg::OP_FEED);
    assign walk_state = (s1_valid_reg && s1_is_feed) ? s1_next_state : walk_state_reg;
    assign walk_dead  = (s1_valid_reg && s1_is_feed) ? s1_next_dead  : walk_dead_reg;
    assign base_state = req.word_start ? start_state_reg : walk_state;
    assign base_dead  = req.word_start ? 1'b0 : walk_dead;
    assign req_sym_ok = ({1'b0, req.symbol} < SYM_LIMIT);
    assign lookup_ok  = !base_dead && ({1'b0, base_state} < ROW_LIMIT) && req_sym_ok;
    assign trans_ok   = ({1'b0, req.source_state} < ROW_LIMIT) && req_sym_ok
                        && ({1'b0, req.target_state} < ROW_LIMIT);

    assign new_entry.valid  = 1'b1;
    assign new_entry.target = req.target_state;

    // Table port: clearing pass, else transition write or symbol lookup
    assign tbl_we    = clr_busy
                       || (accept && (req.operation == dwr_pkg::OP_WRITE_TRANS) && trans_ok);
    assign tbl_waddr = clr_busy ? clr_addr
                       : {req.source_state[ROW_W-1:0], req.symbol[SYM_W-1:0]};
    assign tbl_wdata = clr_busy ? '0 : new_entry;
    assign tbl_re    = accept && (req.operation == dwr_pkg::OP_FEED) && lookup_ok;
    assign tbl_raddr = {base_state[ROW_W-1:0], req.symbol[SYM_W-1:0]};

    dwr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // Table read stage: advance or stop the walk
    // ------------------------------------------------------------------
    assign s1_entry      = dwr_pkg::entry_t'(tbl_rdata);
    assign s1_hit        = s1_lookup_ok_reg && s1_entry.valid;
    assign s1_next_state = s1_hit ? s1_entry.target : s1_base_state_reg;
    assign s1_next_dead  = !s1_hit;

    assign s1_has_res = (s1_req_reg.operation == dwr_pkg::OP_EMPTY_QUERY)
                        || (s1_is_feed && s1_req_reg.word_end);
    assign s1_last_state = s1_is_feed ? s1_next_state : start_state_reg;
    assign s1_end_dead   = s1_is_feed && s1_next_dead;
    assign s1_end_ok     = ({1'b0, s1_last_state} < ROW_LIMIT);
    assign s1_src_ok     = ({1'b0, s1_req_reg.source_state} < ROW_LIMIT);

    // Flag port: clearing pass, else flag write or end-state lookup
    assign flg_we    = clr_busy
                       || (s1_move && (s1_req_reg.operation == dwr_pkg::OP_SET_FLAG)
                           && s1_src_ok);
    assign flg_waddr = clr_busy ? clr_addr[TBL_ADDR_W-1 -: ROW_W]
                       : s1_req_reg.source_state[ROW_W-1:0];
    assign flg_wdata = clr_busy ? 1'b0 : s1_req_reg.accepting_bit;
    assign flg_re    = s1_move && s1_has_res && s1_end_ok;
    assign flg_raddr = s1_last_state[ROW_W-1:0];

    dwr_ram #(
        .WIDTH (1),
        .DEPTH (NUM_ROWS)
    ) u_flags (
        .clk   (clk),
        .we    (flg_we),
        .waddr (flg_waddr),
        .wdata (flg_wdata),
        .re    (flg_re),
        .raddr (flg_raddr),
        .rdata (flg_rdata)
    );

    // ------------------------------------------------------------------
    // Stage valid bits and result handshake
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s2_move && s2_has_res_reg)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            walk_state_reg  <= '0;
            walk_dead_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_state_reg <= cfg_wdata;
            end
            // Commit the walk as a fed symbol leaves the table stage
            if (s1_move && s1_is_feed)
            begin
                walk_state_reg <= s1_next_state;
                walk_dead_reg  <= s1_next_dead;
            end
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg        <= req;
            s1_base_state_reg <= base_state;
            s1_lookup_ok_reg  <= lookup_ok;
        end
        if (s1_move)
        begin
            s2_has_res_reg <= s1_has_res;
            s2_state_reg   <= s1_last_state;
            s2_dead_reg    <= s1_end_dead;
            s2_flag_ok_reg <= s1_end_ok;
        end
        if (s2_move && s2_has_res_reg)
        begin
            res_reg.accepted      <= !s2_dead_reg && s2_flag_ok_reg && flg_rdata[0];
            res_reg.last_state    <= s2_state_reg;
            res_reg.no_transition <= s2_dead_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    // A held table lookup must not see its memory rewritten
    a_table_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !tbl_we)
        else $error("table written while a lookup is held");

    // The pipeline stays empty while the clearing pass runs
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> (!s1_valid_reg && !s2_valid_reg && !res_valid_reg))
        else $error("request in flight during clearing pass");

    // Every result comes from a result-bearing request in the flag stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s2_valid_reg && s2_has_res_reg))
        else $error("result without a source request");
`endif

endmodule

[design/dwr_ram.sv]
// ----------------------------------------------------------------------------
// dwr_ram
// Simple dual-address RAM: one write port, one read port with registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module dwr_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dwr_clear.sv]
// ----------------------------------------------------------------------------
// dwr_clear
// Clear sequencer: after reset, sweep every table address once, one per
// cycle, then go idle for good.
// ----------------------------------------------------------------------------
module dwr_clear #(
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     busy,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    dwr_pkg::clr_state_t state_reg;
    dwr_pkg::clr_state_t state_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dwr_pkg::CLR_SWEEP:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = dwr_pkg::CLR_IDLE;
                end
            end
            dwr_pkg::CLR_IDLE:
            begin
                state_next = dwr_pkg::CLR_IDLE;
            end
            default:
            begin
                state_next = dwr_pkg::CLR_IDLE;
            end
        endcase
    end

    // Outputs and sweep address
    always_comb
    begin
        busy      = 1'b0;
        addr_next = addr_reg;
        case (state_reg)
            dwr_pkg::CLR_SWEEP:
            begin
                busy      = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            dwr_pkg::CLR_IDLE:
            begin
                busy = 1'b0;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dwr_pkg::CLR_SWEEP;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

[verif/dwr_word_checker.sv]
// ----------------------------------------------------------------------------
// dwr_word_checker
// Watches the request, result and start-state ports of the word recognizer.
// Keeps its own copy of the transition table, accepting flags and word walk,
// predicts the verdict of every finished word and empty word query, and
// compares each result taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module dwr_word_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dwr_pkg::STATE_W-1:0] cfg_wdata,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  dwr_pkg::req_t               req,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  dwr_pkg::res_t               res,
    output int                          fail_count,
    output int                          pending
);

    localparam int TABLE_DEPTH = 2 ** (dwr_pkg::STATE_W + dwr_pkg::SYMBOL_W);
    localparam int FLAG_DEPTH  = 2 ** dwr_pkg::STATE_W;

    // Shadow automaton; state and symbol widths cover the default sizes exactly
    dwr_pkg::entry_t             trans_tbl [TABLE_DEPTH];
    logic                        accept_flag [FLAG_DEPTH];
    logic [dwr_pkg::STATE_W-1:0] start_reg;
    logic [dwr_pkg::STATE_W-1:0] walk_state;
    logic                        walk_dead;
    dwr_pkg::res_t               expected_verdicts [$];
    int                          mismatches;

    function automatic string verdict_text(input dwr_pkg::res_t v);
        return $sformatf("acc=%0b last=%0d no_trans=%0b",
                         v.accepted, v.last_state, v.no_transition);
    endfunction

    // Advance the shadow automaton by one request, queue its verdict if any
    task automatic walk_request(input dwr_pkg::req_t r);
        dwr_pkg::entry_t e;
        dwr_pkg::res_t   v;
        case (r.operation)
            dwr_pkg::OP_WRITE_TRANS:
            begin
                e.valid  = 1'b1;
                e.target = r.target_state;
                trans_tbl[{r.source_state, r.symbol}] = e;
            end
            dwr_pkg::OP_SET_FLAG:
            begin
                accept_flag[r.source_state] = r.accepting_bit;
            end
            dwr_pkg::OP_EMPTY_QUERY:
            begin
                v.accepted      = accept_flag[start_reg];
                v.last_state    = start_reg;
                v.no_transition = 1'b0;
                expected_verdicts.push_back(v);
            end
            dwr_pkg::OP_FEED:
            begin
                if (r.word_start)
                begin
                    walk_state = start_reg;
                    walk_dead  = 1'b0;
                end
                // a dead walk ignores symbols until a word_start begins a new word
                if (!walk_dead)
                begin
                    e = trans_tbl[{walk_state, r.symbol}];
                    if (e.valid)
                        walk_state = e.target;
                    else
                        walk_dead = 1'b1;
                end
                if (r.word_end)
                begin
                    v.accepted      = !walk_dead && accept_flag[walk_state];
                    v.last_state    = walk_state;
                    v.no_transition = walk_dead;
                    expected_verdicts.push_back(v);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Compare one taken result with the oldest verdict
    task automatic check_verdict(input dwr_pkg::res_t got);
        dwr_pkg::res_t want;
        if (expected_verdicts.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result: expected none, got %s",
                     $time, verdict_text(got));
        end
        else
        begin
            want = expected_verdicts.pop_front();
            if (got.accepted !== want.accepted || got.last_state !== want.last_state ||
                got.no_transition !== want.no_transition)
            begin
                mismatches++;
                $display("%0t: verdict mismatch: expected %s, got %s",
                         $time, verdict_text(want), verdict_text(got));
            end
        end
    endtask

    // Track ports at each edge: results first, then start state, then requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                trans_tbl[i] = '0;
            for (int i = 0; i < FLAG_DEPTH; i++)
                accept_flag[i] = 1'b0;
            start_reg  = '0;
            walk_state = '0;
            walk_dead  = 1'b0;
            expected_verdicts.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_verdict(res);
            if (cfg_we)
                start_reg = cfg_wdata;
            if (req_valid && !req_stall)
                walk_request(req);
            fail_count <= mismatches;
            pending    <= expected_verdicts.size();
        end
    end

endmodule

[verif/tb_dfa_word_recognizer.sv]
// ----------------------------------------------------------------------------
// tb_dfa_word_recognizer
// Drives the word recognizer with a directed opening and then phases of small
// random automata, each built from a fresh start state and exercised with
// mostly well-formed words plus stray requests. Both channels idle at random,
// except in calm phases. The checker beside the block predicts and compares;
// this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_dfa_word_recognizer;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_GOAL   = 1150;
    localparam int PHASES      = 8;
    localparam int STATE_W     = dwr_pkg::STATE_W;
    localparam int SYMBOL_W    = dwr_pkg::SYMBOL_W;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STATE_W-1:0] cfg_wdata;
    logic               req_valid;
    logic               req_stall;
    dwr_pkg::req_t      req;
    logic               res_valid;
    logic               res_stall;
    dwr_pkg::res_t      res;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 sent_items;
    bit                 calm;

    dfa_word_recognizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    dwr_word_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run; the limit covers the clearing pass after reset
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stall the result side in random runs, mostly short
    initial
    begin
        int run;
        forever
        begin
            if (calm || $urandom_range(0, 99) < 65)
            begin
                res_stall <= 1'b0;
                run = $urandom_range(1, 8);
            end
            else
            begin
                res_stall <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
            end
            repeat (run) @(posedge clk);
        end
    end

    function automatic logic [STATE_W-1:0] rand_state();
        logic [31:0] raw;
        raw = $urandom;
        return raw[STATE_W-1:0];
    endfunction

    function automatic logic [SYMBOL_W-1:0] rand_sym();
        logic [31:0] raw;
        raw = $urandom;
        return raw[SYMBOL_W-1:0];
    endfunction

    function automatic logic rand_bit();
        logic [31:0] raw;
        raw = $urandom;
        return raw[0];
    endfunction

    function automatic dwr_pkg::req_t make_req(input dwr_pkg::op_t op,
                                               input logic [STATE_W-1:0] src,
                                               input logic [SYMBOL_W-1:0] sym,
                                               input logic [STATE_W-1:0] dst,
                                               input logic abit,
                                               input logic w_start, input logic w_end);
        dwr_pkg::req_t r;
        r.operation     = op;
        r.source_state  = src;
        r.symbol        = sym;
        r.target_state  = dst;
        r.accepting_bit = abit;
        r.word_start    = w_start;
        r.word_end      = w_end;
        return r;
    endfunction

    function automatic dwr_pkg::req_t random_req();
        logic [31:0] raw;
        raw = $urandom;
        return dwr_pkg::req_t'(raw[$bits(dwr_pkg::req_t)-1:0]);
    endfunction

    // Hold a request until the block takes it, after an optional idle gap
    task automatic send(input dwr_pkg::req_t r);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 20);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sent_items++;
    endtask

    // Drop valid and wait until every verdict is back and the pipe is empty
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start(input logic [STATE_W-1:0] st);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= st;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Feed one word over the phase alphabet, with an occasional stray letter
    task automatic feed_word(input logic [SYMBOL_W-1:0] letters [$]);
        int                  len;
        logic                fresh;
        logic [SYMBOL_W-1:0] sym;
        len   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        fresh = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                sym = rand_sym();
            else
                sym = letters[$urandom_range(0, letters.size() - 1)];
            send(make_req(dwr_pkg::OP_FEED, rand_state(), sym, rand_state(), rand_bit(),
                          (k == 0) && fresh, k == len - 1));
        end
    endtask

    // Build a small automaton around the start state and exercise it
    task automatic run_phase(input logic [STATE_W-1:0] st, input int goal);
        logic [STATE_W-1:0]  states [$];
        logic [SYMBOL_W-1:0] letters [$];
        int                  n_states;
        int                  n_letters;
        int                  pick;
        logic [STATE_W-1:0]  src;
        states.push_back(st);
        n_states  = $urandom_range(2, 7);
        n_letters = $urandom_range(2, 5);
        for (int i = 0; i < n_states; i++)
            states.push_back(rand_state());
        for (int i = 0; i < n_letters; i++)
            letters.push_back(rand_sym());
        // write most transitions, leave a few holes
        foreach (states[i])
            foreach (letters[j])
                if ($urandom_range(0, 9) != 0)
                    send(make_req(dwr_pkg::OP_WRITE_TRANS, states[i], letters[j],
                                  states[$urandom_range(0, states.size() - 1)],
                                  rand_bit(), rand_bit(), rand_bit()));
        foreach (states[i])
            send(make_req(dwr_pkg::OP_SET_FLAG, states[i], rand_sym(), rand_state(),
                          rand_bit(), rand_bit(), rand_bit()));
        while (sent_items < goal)
        begin
            pick = $urandom_range(0, 99);
            src  = states[$urandom_range(0, states.size() - 1)];
            if (pick < 70)
                feed_word(letters);
            else if (pick < 78)
                send(make_req(dwr_pkg::OP_EMPTY_QUERY, rand_state(), rand_sym(),
                              rand_state(), rand_bit(), rand_bit(), rand_bit()));
            else if (pick < 85)
                send(make_req(dwr_pkg::OP_WRITE_TRANS, src,
                              letters[$urandom_range(0, letters.size() - 1)],
                              states[$urandom_range(0, states.size() - 1)],
                              rand_bit(), rand_bit(), rand_bit()));
            else if (pick < 90)
                send(make_req(dwr_pkg::OP_SET_FLAG, src, rand_sym(), rand_state(),
                              rand_bit(), rand_bit(), rand_bit()));
            else
                send(random_req());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [STATE_W-1:0] st;
        logic [31:0]        draw;
        int                 per_phase;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        req_valid  <= 1'b0;
        req        <= '0;
        sent_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_start(6'd0);

        // Directed: empty table, walk continuing from reset state, dead walks
        send(make_req(dwr_pkg::OP_EMPTY_QUERY, 6'd0, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        send(make_req(dwr_pkg::OP_WRITE_TRANS, 6'd0, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1));
        send(make_req(dwr_pkg::OP_WRITE_TRANS, 6'd63, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_WRITE_TRANS, 6'd63, 8'h00, 6'd63, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_SET_FLAG, 6'd63, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1));
        send(make_req(dwr_pkg::OP_FEED, 6'd63, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b1, 1'b1));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h7F, 6'd0, 1'b0, 1'b1, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        send(make_req(dwr_pkg::OP_SET_FLAG, 6'd0, 8'h00, 6'd0, 1'b1, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_EMPTY_QUERY, 6'd63, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1));
        send(make_req(dwr_pkg::OP_SET_FLAG, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_EMPTY_QUERY, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'hFF, 6'd0, 1'b0, 1'b1, 1'b0));
        send(make_req(dwr_pkg::OP_EMPTY_QUERY, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        send(make_req(dwr_pkg::OP_FEED, 6'd0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        send(make_req(dwr_pkg::OP_WRITE_TRANS, 6'h2A, 8'hAA, 6'h15, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_WRITE_TRANS, 6'h15, 8'h55, 6'h2A, 1'b0, 1'b0, 1'b0));
        send(make_req(dwr_pkg::OP_SET_FLAG, 6'h2A, 8'h55, 6'h15, 1'b1, 1'b0, 1'b0));
        drain();

        // Random phases, each with a start state written before it
        per_phase = (ITEM_GOAL - sent_items) / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0, 3:    st = 6'd63;
                1, 6:    st = 6'd0;
                default:
                begin
                    draw = $urandom_range(1, 62);
                    st   = draw[STATE_W-1:0];
                end
            endcase
            write_start(st);
            calm <= (p % 3 == 2);
            run_phase(st, sent_items + per_phase);
            drain();
        end

        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
design/dwr_pkg.sv
design/dwr_ram.sv
design/dwr_clear.sv
design/dfa_word_recognizer.sv
verif/dwr_word_checker.sv
verif/tb_dfa_word_recognizer.sv
